// File: src/adxd_pkg.sv
// Shared types, register indexes and constants of the ADX ADPCM frame decoder.
package adxd_pkg;

  localparam int unsigned SAMPLES_PER_FRAME = 32;
  localparam int unsigned FRAME_BYTES       = 18;
  localparam int unsigned OUT_DEPTH         = 8;
  localparam int unsigned COEF_SHIFT        = 12;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 16;
  localparam logic [14:0] KEY_MASK          = 15'h7FFF;

  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ONE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TWO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCRAMBLE_ON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_START     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MULT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ADD       = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               channel;
    logic               last;
  } out_t;

  // Control of the sample unit for one cycle.
  typedef struct packed {
    logic       clr;   // clear both predictor sets
    logic       mul;   // form the products for the next sample
    logic       fin;   // finish the sample and update the predictors
    logic       ch;    // predictor set
    logic [3:0] code;  // signed 4-bit code
  } dec_ctl_t;

endpackage

// File: src/adx_adpcm_frame_decoder_top.sv
// ADX ADPCM frame decoder: byte intake, frame sequencing, key, left-sample RAM.
// A data byte holds two samples, each set by the predictor recurrence (registered
// multiply, then add and shift) in the sample unit. An accepted byte waits in the hold
// register until taken; its products are registered, then its results go to the result
// queue or RAM. A new byte is taken while results wait, given room for its four results.
// Reset (synchronous) clears predictors, key, scale, frame position, channel and queue;
// the left-sample RAM is not cleared and holds no data until a left frame writes it.
module adx_adpcm_frame_decoder_top #(
  parameter int unsigned OUT_DEPTH = adxd_pkg::OUT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  adxd_pkg::in_t                       src_data,
  output logic                                res_valid,
  input  logic                                res_stall,
  output adxd_pkg::out_t                      res_data,
  input  logic                                cfg_we,
  input  logic [adxd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adxd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned BUF_AW = $clog2(adxd_pkg::SAMPLES_PER_FRAME);
  localparam int unsigned CNT_W  = $clog2(OUT_DEPTH) + 1;
  localparam int unsigned ROOM   = OUT_DEPTH - 4;
  localparam logic [4:0]  LAST_POS = 5'(adxd_pkg::FRAME_BYTES - 1);

  localparam logic [1:0] STEP_M0 = 2'd0;
  localparam logic [1:0] STEP_S0 = 2'd1;
  localparam logic [1:0] STEP_M1 = 2'd2;
  localparam logic [1:0] STEP_S1 = 2'd3;

  localparam logic [1:0] MODE_MONO  = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;

  // configuration
  logic signed [15:0] coeff_one;
  logic signed [15:0] coeff_two;
  logic [1:0]         channel_count;
  logic               scramble_on;
  logic [15:0]        key_start;
  logic [15:0]        key_mult;
  logic [15:0]        key_add;

  // intake and frame state
  adxd_pkg::in_t      hold;
  logic               hold_valid;
  logic [4:0]         pos;
  logic               cur_ch;
  logic [15:0]        key_now;
  logic [16:0]        scale_now;
  logic [7:0]         scale_hi;

  // engine
  logic               busy;
  logic [1:0]         step;
  logic [1:0]         mode;
  logic               chsel;
  logic [7:0]         dbyte;
  logic [BUF_AW-1:0]  idx;

  logic               take;
  logic               room_ok;
  logic               engine_free;
  logic [1:0]         push_now;
  logic [CNT_W:0]     fill_after;
  logic [CNT_W-1:0]   q_count;

  logic               start;
  logic [4:0]         pos_eff;
  logic               ch_eff;
  logic [15:0]        key_eff;
  logic [15:0]        key_use;
  logic               stereo;
  logic [4:0]         pos_m2;
  logic [31:0]        key_prod;
  logic [15:0]        key_step;
  logic [4:0]         pos_next;

  logic               fin_step;
  logic               ram_we;
  logic [BUF_AW-1:0]  ram_waddr;
  logic [BUF_AW-1:0]  ram_raddr;
  logic [31:0]        ram_rdata;
  logic signed [31:0] dec_sample;
  adxd_pkg::dec_ctl_t dec_ctl;
  logic               push0;
  logic               push1;
  adxd_pkg::out_t     din0;
  adxd_pkg::out_t     din1;

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_one     <= '0;
      coeff_two     <= '0;
      channel_count <= 2'd1;
      scramble_on   <= 1'b0;
      key_start     <= '0;
      key_mult      <= '0;
      key_add       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adxd_pkg::CFG_COEFF_ONE:     coeff_one     <= cfg_data;
        adxd_pkg::CFG_COEFF_TWO:     coeff_two     <= cfg_data;
        adxd_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        adxd_pkg::CFG_SCRAMBLE_ON:   scramble_on   <= cfg_data[0];
        adxd_pkg::CFG_KEY_START:     key_start     <= cfg_data;
        adxd_pkg::CFG_KEY_MULT:      key_mult      <= cfg_data;
        adxd_pkg::CFG_KEY_ADD:       key_add       <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // intake: a request waits in the hold register until the engine takes it
  assign fin_step    = busy && (step == STEP_S0 || step == STEP_S1);
  assign engine_free = !busy || (step == STEP_S1);

  always_comb begin
    push_now = 2'd0;
    if (fin_step) begin
      unique case (mode)
        MODE_MONO:  push_now = 2'd1;
        MODE_RIGHT: push_now = 2'd2;
        default:    push_now = 2'd0;
      endcase
    end
  end

  // Leave room for all four results of the next byte.
  assign fill_after = (CNT_W+1)'(q_count) + (CNT_W+1)'(push_now);
  assign room_ok    = fill_after <= (CNT_W+1)'(ROOM);
  assign take       = hold_valid && engine_free && room_ok;
  assign src_stall  = hold_valid && !take;

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      hold <= src_data;
    end
  end

  // ---------------------------------------------------------------------------
  // frame sequencing for the byte being taken
  assign start    = hold.stream_start;
  assign stereo   = channel_count[1];
  assign pos_eff  = start ? 5'd0 : pos;
  assign ch_eff   = start ? 1'b0 : cur_ch;
  assign key_eff  = start ? (scramble_on ? key_start : 16'd0) : key_now;
  assign key_use  = scramble_on ? key_eff : 16'd0;
  assign pos_m2   = pos_eff - 5'd2;
  assign key_prod = key_eff * key_mult;
  assign key_step = {1'b0, key_prod[14:0] + key_add[14:0]} & {1'b0, adxd_pkg::KEY_MASK};
  assign pos_next = (pos_eff == LAST_POS) ? 5'd0 : pos_eff + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pos        <= '0;
      cur_ch     <= 1'b0;
      key_now    <= '0;
      scale_now  <= '0;
      scale_hi   <= '0;
      busy       <= 1'b0;
      step       <= STEP_M0;
      mode       <= MODE_MONO;
    end else begin
      hold_valid <= (src_valid && !src_stall) || (hold_valid && !take);

      // start the engine on a data byte, else advance it; a byte taken at the
      // last step restarts it
      if (take && pos_eff > 5'd1) begin
        busy <= 1'b1;
        step <= STEP_M0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == STEP_S1) begin
          busy <= 1'b0;
        end
      end

      if (take) begin
        pos <= pos_next;
        if (pos_eff == LAST_POS) begin
          cur_ch  <= stereo ? !ch_eff : 1'b0;
          key_now <= scramble_on ? key_step : key_eff;
        end else begin
          cur_ch  <= ch_eff;
          key_now <= key_eff;
        end

        priority if (pos_eff == 5'd0) begin
          scale_hi <= hold.data_byte;
        end else if (pos_eff == 5'd1) begin
          scale_now <= {1'b0, {scale_hi, hold.data_byte} ^ key_use} + 17'd1;
        end else begin
          if (!stereo) begin
            mode <= MODE_MONO;
          end else if (!ch_eff) begin
            mode <= MODE_LEFT;
          end else begin
            mode <= MODE_RIGHT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dbyte <= hold.data_byte;
      chsel <= stereo && ch_eff;
      idx   <= BUF_AW'({pos_m2, 1'b0});
    end
  end

  // ---------------------------------------------------------------------------
  // sample unit
  always_comb begin
    dec_ctl      = '0;
    dec_ctl.clr  = take && start;
    dec_ctl.mul  = busy && (step == STEP_M0 || step == STEP_M1);
    dec_ctl.fin  = fin_step;
    dec_ctl.ch   = chsel;
    dec_ctl.code = (step == STEP_M0) ? dbyte[7:4] : dbyte[3:0];
  end

  adxd_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .ctl       (dec_ctl),
    .coeff_one (coeff_one),
    .coeff_two (coeff_two),
    .scale     (scale_now),
    .sample    (dec_sample)
  );

  // ---------------------------------------------------------------------------
  // left-sample RAM: left frames write, right frames read in the cycle before the data is used
  assign ram_raddr = (step == STEP_M0) ? idx : (idx | BUF_AW'(1));
  assign ram_waddr = (step == STEP_S0) ? idx : (idx | BUF_AW'(1));
  assign ram_we    = fin_step && (mode == MODE_LEFT);

  adxd_ram #(
    .WIDTH (32),
    .DEPTH (adxd_pkg::SAMPLES_PER_FRAME)
  ) u_left_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (dec_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // result queue
  always_comb begin
    push0        = fin_step && (mode == MODE_MONO || mode == MODE_RIGHT);
    push1        = fin_step && (mode == MODE_RIGHT);
    din0         = '0;
    din1         = '0;
    din1.sample  = dec_sample;
    din1.channel = 1'b1;
    din1.last    = (step == STEP_S1);
    if (mode == MODE_RIGHT) begin
      din0.sample  = ram_rdata;
      din0.channel = 1'b0;
      din0.last    = 1'b0;
    end else begin
      din0.sample  = dec_sample;
      din0.channel = 1'b0;
      din0.last    = (step == STEP_S1);
    end
  end

  adxd_ofifo #(
    .DEPTH (OUT_DEPTH)
  ) u_ofifo (
    .clk   (clk),
    .rst   (rst),
    .push0 (push0),
    .push1 (push1),
    .din0  (din0),
    .din1  (din1),
    .valid (res_valid),
    .stall (res_stall),
    .dout  (res_data),
    .count (q_count)
  );

  // ---------------------------------------------------------------------------
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q_count + CNT_W'(push_now)) <= CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_sample_pairing: assert property (@(posedge clk) disable iff (rst)
    (busy && step == STEP_M0) |=> (busy && step == STEP_S0))
    else $error("sample step did not follow its product step");

  a_left_silent: assert property (@(posedge clk) disable iff (rst)
    (busy && mode == MODE_LEFT) |-> !push0)
    else $error("left frame produced a result");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (push0 && (din0.last || (push1 && din1.last))) |-> (step == STEP_S1))
    else $error("final result flagged before the second sample");

endmodule

// File: src/adxd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module adxd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/adxd_dec.sv
// Sample unit: predictor registers and the multiply/accumulate step with registered products.
module adxd_dec (
  input  logic                clk,
  input  logic                rst,
  input  adxd_pkg::dec_ctl_t  ctl,
  input  logic signed [15:0]  coeff_one,
  input  logic signed [15:0]  coeff_two,
  input  logic [16:0]         scale,
  output logic signed [31:0]  sample
);

  logic signed [31:0] prev_newer [2];
  logic signed [31:0] prev_older [2];

  logic signed [47:0] p1_full;
  logic signed [47:0] p2_full;
  logic signed [21:0] p3_full;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [31:0] p3;
  logic signed [31:0] pred_sum;
  logic signed [31:0] pred;

  assign p1_full = coeff_one * prev_newer[ctl.ch];
  assign p2_full = coeff_two * prev_older[ctl.ch];
  assign p3_full = $signed(ctl.code) * $signed({1'b0, scale});

  // Products are registered; the sum and shift finish in the next cycle.
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      p1 <= p1_full[31:0];
      p2 <= p2_full[31:0];
      p3 <= {{10{p3_full[21]}}, p3_full};
    end
  end

  assign pred_sum = p1 + p2;
  assign pred     = pred_sum >>> adxd_pkg::COEF_SHIFT;
  assign sample   = p3 + pred;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_newer[0] <= '0;
      prev_newer[1] <= '0;
      prev_older[0] <= '0;
      prev_older[1] <= '0;
    end else if (ctl.clr) begin
      // Stream start wins over a sample finishing in the same cycle.
      prev_newer[0] <= '0;
      prev_newer[1] <= '0;
      prev_older[0] <= '0;
      prev_older[1] <= '0;
    end else if (ctl.fin) begin
      prev_older[ctl.ch] <= prev_newer[ctl.ch];
      prev_newer[ctl.ch] <= sample;
    end
  end

endmodule

// File: src/adxd_ofifo.sv
// Result queue: up to two writes and one read per cycle.
module adxd_ofifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push0,
  input  logic                       push1,
  input  adxd_pkg::out_t             din0,
  input  adxd_pkg::out_t             din1,
  output logic                       valid,
  input  logic                       stall,
  output adxd_pkg::out_t             dout,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int unsigned AW = $clog2(DEPTH);

  adxd_pkg::out_t   mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW-1:0]    wptr_inc;
  logic             pop;
  logic [1:0]       n_push;

  assign valid    = (count != '0);
  assign dout     = mem[rptr];
  assign pop      = valid && !stall;
  assign wptr_inc = wptr + AW'(1);
  assign n_push   = {1'b0, push0} + {1'b0, push1};

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wptr] <= din0;
    end
    if (push1) begin
      mem[wptr_inc] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(n_push);
      if (pop) begin
        rptr <= rptr + AW'(1);
      end
      count <= count + (AW+1)'(n_push) - (AW+1)'(pop);
    end
  end

endmodule
